[rtl/core/mbaf_pkg.sv]
package mbaf_pkg;

  localparam int unsigned FrameBytes = 7;   // six payload bytes plus LRC
  localparam int unsigned FrameChars = 17;
  localparam int unsigned PosW       = 5;

  localparam logic [PosW-1:0] PosColon = 5'd0;
  localparam logic [PosW-1:0] PosCr    = 5'd15;
  localparam logic [PosW-1:0] PosLf    = 5'd16;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // configuration register indexes
  localparam logic [7:0] RegSlaveAddr = 8'd0;
  localparam logic [7:0] RegFuncCode  = 8'd1;

  // frame handed from the request stage to the serialiser; byte 0 is sent first
  typedef struct packed {
    logic                        vld;
    logic [FrameBytes-1:0][7:0]  bytes;
  } frm_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib >= 4'hA) begin
      ch = {4'h0, nib} + 8'h37;
    end else begin
      ch = {4'h0, nib} + 8'h30;
    end
    return ch;
  endfunction

endpackage

[rtl/core/mbaf_req_stage.sv]
module mbaf_req_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         start_register_i,
  input  logic [15:0]         register_count_i,
  input  logic [7:0]          slave_address_i,
  input  logic [6:0]          function_code_i,
  output mbaf_pkg::frm_t      frm_o,
  input  logic                frm_take_i
);
  import mbaf_pkg::*;

  logic        vld_q, vld_d;
  logic [15:0] start_q;
  logic [15:0] count_q;
  logic [7:0]  sum;
  logic        load;

  assign in_ready_o = !vld_q || frm_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (frm_take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      start_q <= start_register_i;
      count_q <= register_count_i;
    end
  end

  // LRC: two's complement of the 8-bit byte sum
  assign sum = slave_address_i + {1'b0, function_code_i} + start_q[15:8] + start_q[7:0]
             + count_q[15:8] + count_q[7:0];

  always_comb begin
    frm_o.vld      = vld_q;
    frm_o.bytes[0] = slave_address_i;
    frm_o.bytes[1] = {1'b0, function_code_i};
    frm_o.bytes[2] = start_q[15:8];
    frm_o.bytes[3] = start_q[7:0];
    frm_o.bytes[4] = count_q[15:8];
    frm_o.bytes[5] = count_q[7:0];
    frm_o.bytes[6] = 8'h00 - sum;
  end

endmodule

[rtl/core/mbaf_serialiser.sv]
module mbaf_serialiser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbaf_pkg::frm_t      frm_i,
  output logic                frm_take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          tx_char_o,
  output logic                last_char_o
);
  import mbaf_pkg::*;

  logic                        busy_q, busy_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic [FrameBytes-1:0][7:0]  frame_q;
  logic                        ovld_q, ovld_d;
  logic [7:0]                  char_q;
  logic                        last_q;
  logic                        out_free;
  logic                        emit;
  logic                        load;
  logic [3:0]                  nib_idx;
  logic [2:0]                  byte_idx;
  logic [7:0]                  cur_byte;
  logic [7:0]                  cur_char;

  assign out_free   = !ovld_q || out_ready_i;
  assign emit       = busy_q && out_free;
  assign frm_take_o = !busy_q || (emit && (pos_q == PosLf));
  assign load       = frm_i.vld && frm_take_o;

  // positions 1..14 carry nibbles, high nibble first
  assign nib_idx  = 4'(pos_q - 5'd1);
  assign byte_idx = (nib_idx[3:1] == 3'd7) ? 3'd6 : nib_idx[3:1];
  assign cur_byte = frame_q[byte_idx];

  always_comb begin
    case (pos_q)
      PosColon: cur_char = ChColon;
      PosCr:    cur_char = ChCr;
      PosLf:    cur_char = ChLf;
      default:  cur_char = hex_char(nib_idx[0] ? cur_byte[3:0] : cur_byte[7:4]);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    ovld_d = ovld_q;
    if (emit) begin
      ovld_d = 1'b1;
      if (pos_q == PosLf) begin
        busy_d = 1'b0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frm_i.bytes;
    end
    if (emit) begin
      char_q <= cur_char;
      last_q <= (pos_q == PosLf);
    end
  end

  assign out_valid_o = ovld_q;
  assign tx_char_o   = char_q;
  assign last_char_o = last_q;

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> tx_char_o == ChLf)
    else $error("last flag on a character other than LF");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLf)
    else $error("character position beyond frame end");

  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pos_q == '0)
    else $error("idle serialiser with nonzero position");

  a_load_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && busy_q |-> emit && pos_q == PosLf)
    else $error("frame loaded over one still in progress");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_char_o))
    else $error("stalled character changed");

endmodule

[rtl/core/modbus_ascii_request_framer_unit.sv]
// Channel   Dir  Handshake                         Payload
// s_axis    in   s_axis_tvalid / s_axis_tready     tdata[15:0] start_register,
//                                                  tdata[31:16] register_count
// m_axis    out  m_axis_tvalid / m_axis_tready     tdata[7:0] tx_char, tlast last_char
// cfg       in   cfg_valid_i / cfg_ready_o         cfg_index_i, cfg_data_i
//
// Each request gives 17 characters, one per cycle through the serialiser's
// output register while m_axis_tready is held high.
// One request waits in the request register while the previous frame drains;
// the next frame starts in the cycle after the previous LF, with no gap.
// Reset clears the valid flags and position and sets slave address 1, code 3.
// Output stalls hold the character register and back up into s_axis_tready.
module modbus_ascii_request_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] start_register, [31:16] register_count
  // character stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_char
  output logic        m_axis_tlast,   // last_char
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import mbaf_pkg::*;

  logic [7:0] slave_addr_q;
  logic [6:0] func_code_q;
  logic       cfg_wr;
  frm_t       frm;
  logic       frm_take;

  // writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      func_code_q  <= 7'd3;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegSlaveAddr: slave_addr_q <= cfg_data_i;
        RegFuncCode:  func_code_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // request register and LRC
  mbaf_req_stage u_req (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .start_register_i (s_axis_tdata[15:0]),
    .register_count_i (s_axis_tdata[31:16]),
    .slave_address_i  (slave_addr_q),
    .function_code_i  (func_code_q),
    .frm_o            (frm),
    .frm_take_i       (frm_take)
  );

  // colon, hex digits, CR LF, one transfer per cycle while m_axis_tready is high
  mbaf_serialiser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_i       (frm),
    .frm_take_o  (frm_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tx_char_o   (m_axis_tdata),
    .last_char_o (m_axis_tlast)
  );

endmodule
